/* hdl/gmps_pkg.sv */
// Package for the grid maze path search block: payload structs, control and
// status structs between the top level and the row cells, and fixed codes.
// No dependencies.
package gmps_pkg;

   localparam int COORD_W   = 4;                 // width of a row or column coordinate
   localparam int COORD_LIM = 1 << COORD_W;      // coordinates are below this
   localparam int CSR_W     = 5;                 // widest configuration register
   localparam int CSR_IDX_W = 1;                 // register index width

   localparam logic [CSR_W-1:0]     DIM_RESET    = 5'd16;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] cell_row;
      logic [COORD_W-1:0] cell_col;
      logic               is_wall;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] end_row;
      logic [COORD_W-1:0] end_col;
   } req_type;

   typedef struct packed {
      logic path_found;
      logic query_error;
   } rsp_type;

   // Broadcast from the sequencer to every row cell.
   typedef struct packed {
      logic               load;     // seed the reached set at row/col
      logic               step;     // one flood step
      logic               wr;       // write wall bit at row/col
      logic               wall;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] end_row;
      logic [COORD_W-1:0] end_col;
   } cell_ctl_type;

   typedef struct packed {
      logic changed;   // this step adds at least one cell
      logic hit;       // target cell is already reached
   } cell_sts_type;

endpackage

/* hdl/grid_maze_path_search.sv */
// Grid maze path search, top level: request decode, sequencer and the chain
// of row cells that floods the reached set. Depends on gmps_pkg, gmps_cell.
//
// Usage:
//   req_start/busy: a request transfers at a clock edge with req_start high
//   and busy low. op OP_WRITE stores one wall bit (no response); it can be
//   issued every idle cycle. op OP_QUERY asks if end is reachable from start.
//   rsp_valid strobes for exactly one cycle with rsp_item; the receiver
//   cannot stall, so the response is simply dropped onto the ports.
//   csr_wr_en/csr_index/csr_data: register writes, taken at once; the user
//   must write them only while idle, as the block does not enforce it.
//   num_rows/num_cols are clamped to 1..MAX_ROWS/MAX_COLS.
// Timing:
//   Out-of-grid or start-equals-end queries answer in the cycle after the
//   transfer. Otherwise the transfer seeds the start cell, then each flood
//   step grows the reached set by one cell in every direction across all
//   rows at once; the answer comes out in the cycle after the target is
//   reached or the set stops growing. busy is high during the flood.
// Reset: synchronous; all walls open, registers at 16, sequencer idle.
module grid_maze_path_search
   import gmps_pkg::*;
#(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   input  req_type              req_item,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int DIM_W = (RW > CW) ? ((RW > CSR_W) ? RW : CSR_W)
                                    : ((CW > CSR_W) ? CW : CSR_W);

   typedef enum logic {ST_IDLE, ST_SEARCH} state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic [COORD_W-1:0] end_row_ff, end_col_ff;
   logic [CSR_W-1:0]   num_rows_ff, num_cols_ff;

   logic [DIM_W-1:0]   rows_raw, cols_raw, rows_eff, cols_eff;
   logic               accept, is_query, coord_err, same_cell;
   cell_ctl_type       ctl;
   logic [MAX_ROWS-1:0] row_on;
   logic [MAX_COLS-1:0] col_mask;
   logic [MAX_COLS-1:0] reach_w [MAX_ROWS];
   cell_sts_type        sts_w   [MAX_ROWS];
   logic                any_changed, any_hit;

   // --- configuration registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= DIM_RESET;
         num_cols_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_ROWS: num_rows_ff <= csr_data;
            CSR_NUM_COLS: num_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp to 1..MAX; zero acts as one
   assign rows_raw = DIM_W'(num_rows_ff);
   assign cols_raw = DIM_W'(num_cols_ff);
   assign rows_eff = (rows_raw == '0) ? DIM_W'(1) :
                     (rows_raw > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_raw;
   assign cols_eff = (cols_raw == '0) ? DIM_W'(1) :
                     (cols_raw > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_raw;

   always_comb begin
      for (int i = 0; i < MAX_ROWS; i++) row_on[i] = DIM_W'(i) < rows_eff;
      for (int j = 0; j < MAX_COLS; j++) col_mask[j] = DIM_W'(j) < cols_eff;
   end

   // --- request decode ---
   assign busy      = (state_ff == ST_SEARCH);
   assign accept    = req_start && !busy;
   assign is_query  = accept && (req_item.op == OP_QUERY);
   assign coord_err = (DIM_W'(req_item.start_row) >= rows_eff) ||
                      (DIM_W'(req_item.end_row)   >= rows_eff) ||
                      (DIM_W'(req_item.start_col) >= cols_eff) ||
                      (DIM_W'(req_item.end_col)   >= cols_eff);
   assign same_cell = (req_item.start_row == req_item.end_row) &&
                      (req_item.start_col == req_item.end_col);

   // broadcast to the row cells; a write uses the cell coordinates, a seed
   // uses the start coordinates
   always_comb begin
      ctl.load    = is_query && !coord_err && !same_cell;
      ctl.step    = (state_ff == ST_SEARCH);
      ctl.wr      = accept && (req_item.op == OP_WRITE);
      ctl.wall    = req_item.is_wall;
      ctl.row     = ctl.wr ? req_item.cell_row : req_item.start_row;
      ctl.col     = ctl.wr ? req_item.cell_col : req_item.start_col;
      ctl.end_row = end_row_ff;
      ctl.end_col = end_col_ff;
   end

   // --- chain of row cells; each row sees its north and south neighbor ---
   for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
      logic [MAX_COLS-1:0] north_w, south_w;
      if (g == 0) begin : g_top
         assign north_w = '0;
      end else begin : g_mid_n
         assign north_w = reach_w[g-1];
      end
      if (g == MAX_ROWS - 1) begin : g_bot
         assign south_w = '0;
      end else begin : g_mid_s
         assign south_w = reach_w[g+1];
      end
      gmps_cell #(
         .MAX_COLS (MAX_COLS),
         .ROW_IDX  (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .row_on      (row_on[g]),
         .col_mask    (col_mask),
         .north_reach (north_w),
         .south_reach (south_w),
         .reach       (reach_w[g]),
         .sts         (sts_w[g])
      );
   end

   always_comb begin
      any_changed = 1'b0;
      any_hit     = 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) begin
         any_changed = any_changed | sts_w[i].changed;
         any_hit     = any_hit     | sts_w[i].hit;
      end
   end

   // --- sequencer and response register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (is_query) begin
                  if (coord_err) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_ff.path_found  <= 1'b0;
                     rsp_ff.query_error <= 1'b1;
                  end else if (same_cell) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_ff.path_found  <= 1'b1;
                     rsp_ff.query_error <= 1'b0;
                  end else begin
                     state_ff   <= ST_SEARCH;
                     end_row_ff <= req_item.end_row;
                     end_col_ff <= req_item.end_col;
                  end
               end
            end
            ST_SEARCH: begin
               // target reached, or the reached set is closed
               if (any_hit || !any_changed) begin
                  state_ff           <= ST_IDLE;
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.path_found  <= any_hit;
                  rsp_ff.query_error <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* hdl/gmps_cell.sv */
// One grid row of the maze search: wall bits, reached bits and the flood step.
// Depends on gmps_pkg.
module gmps_cell
   import gmps_pkg::*;
#(
   parameter int MAX_COLS = 16,
   parameter int ROW_IDX  = 0
)(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic                row_on,
   input  logic [MAX_COLS-1:0] col_mask,
   input  logic [MAX_COLS-1:0] north_reach,
   input  logic [MAX_COLS-1:0] south_reach,
   output logic [MAX_COLS-1:0] reach,
   output cell_sts_type        sts
);

   logic [MAX_COLS-1:0] wall_ff,  wall_in;
   logic [MAX_COLS-1:0] reach_ff, reach_in;
   logic [MAX_COLS-1:0] col_hot;
   logic [MAX_COLS-1:0] end_hot;
   logic [MAX_COLS-1:0] passable;
   logic [MAX_COLS-1:0] grow;
   logic                row_hit;
   logic                end_hit;

   assign row_hit = (ROW_IDX < COORD_LIM) && (ctl.row == COORD_W'(ROW_IDX));
   assign end_hit = (ROW_IDX < COORD_LIM) && (ctl.end_row == COORD_W'(ROW_IDX));

   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         col_hot[j] = (j < COORD_LIM) && (ctl.col == COORD_W'(j));
         end_hot[j] = (j < COORD_LIM) && (ctl.end_col == COORD_W'(j));
      end
   end

   // open and inside the grid in use
   assign passable = ~wall_ff & col_mask & {MAX_COLS{row_on}};
   assign grow     = passable & ~reach_ff &
                     ((reach_ff << 1) | (reach_ff >> 1) | north_reach | south_reach);

   always_comb begin
      wall_in  = wall_ff;
      reach_in = reach_ff;
      if (ctl.wr && row_hit) begin
         wall_in = (wall_ff & ~col_hot) | (col_hot & {MAX_COLS{ctl.wall}});
      end
      if (ctl.load) begin
         reach_in = row_hit ? col_hot : '0;
      end else if (ctl.step) begin
         reach_in = reach_ff | grow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_ff  <= '0;
         reach_ff <= '0;
      end else begin
         wall_ff  <= wall_in;
         reach_ff <= reach_in;
      end
   end

   assign reach       = reach_ff;
   assign sts.changed = |grow;
   assign sts.hit     = end_hit && |(reach_ff & end_hot);

endmodule

/* verif/tb.sv */
// Self-checking testbench for grid_maze_path_search: cell writes and reachability
// queries against a flood-fill predictor, with random gaps and config changes.
// Depends on gmps_pkg and the grid_maze_path_search RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gmps_pkg::*;

   localparam int GRID         = COORD_LIM;       // store is GRID x GRID cells
   localparam int REQ_W        = $bits(req_type);
   localparam int DRAIN_CYCLES = 300;             // wait after the last item, to outlast the longest flood
   localparam int STALL_LIMIT  = 4000;            // cycles with no transfer at all
   localparam int ITEM_TARGET  = 700;

   logic    clock;
   logic    reset;
   logic    req_start;
   req_type req_item;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   grid_maze_path_search u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------
   // Shadow state of the block: wall store and the two size registers.
   // Updated by the monitor at the edge where the transfer happens.
   // ------------------------------------------------------------------
   logic            wall_bits [GRID][GRID];
   logic [CSR_W-1:0] rows_reg;
   logic [CSR_W-1:0] cols_reg;

   req_type req_backlog [$];    // items waiting for the driver
   rsp_type answers_due [$];    // predicted query answers, oldest first
   rsp_type want;

   int  items_queued  = 0;      // pushed into req_backlog so far
   int  items_taken   = 0;      // transferred into the block so far
   int  mismatch_count = 0;
   int  stall_cycles  = 0;
   int  gap_left      = 0;
   bit  req_taken     = 1'b0;   // request transfer at the last rising edge
   bit  no_gap_run    = 1'b0;   // back-to-back stretch in progress

   // Sizes in use: zero acts as one, anything past the store is clamped.
   function automatic int eff_dim(logic [CSR_W-1:0] v);
      if (v == '0) return 1;
      if (v > GRID) return GRID;
      return int'(v);
   endfunction

   // Flood fill from the start cell. Search order does not matter for the
   // yes/no answer, so a plain stack walk is enough. The start cell is entered
   // even when it is a wall; every other cell must be open and in the grid.
   function automatic rsp_type reachable_answer(req_type q);
      int      rows, cols, cur, r, c, nr, nc;
      bit      seen [GRID][GRID];
      int      frontier [$];
      rsp_type ans;
      rows = eff_dim(rows_reg);
      cols = eff_dim(cols_reg);
      ans  = '0;
      if (q.start_row >= rows || q.end_row >= rows ||
          q.start_col >= cols || q.end_col >= cols) begin
         ans.query_error = 1'b1;
         return ans;
      end
      if (q.start_row == q.end_row && q.start_col == q.end_col) begin
         ans.path_found = 1'b1;
         return ans;
      end
      seen = '{default: '{default: 1'b0}};
      seen[q.start_row][q.start_col] = 1'b1;
      frontier.push_back(int'(q.start_row) * GRID + int'(q.start_col));
      while (frontier.size() > 0) begin
         cur = frontier.pop_back();
         r   = cur / GRID;
         c   = cur % GRID;
         if (r == q.end_row && c == q.end_col) begin
            ans.path_found = 1'b1;
            return ans;
         end
         for (int d = 0; d < 4; d++) begin
            // d: 0 north, 1 east, 2 south, 3 west
            nr = r + ((d == 0) ? -1 : (d == 2) ? 1 : 0);
            nc = c + ((d == 3) ? -1 : (d == 1) ? 1 : 0);
            if (nr >= 0 && nr < rows && nc >= 0 && nc < cols &&
                !wall_bits[nr][nc] && !seen[nr][nc]) begin
               seen[nr][nc] = 1'b1;
               frontier.push_back(nr * GRID + nc);
            end
         end
      end
      return ans;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Gap after each request transfer: mostly none or short, a few long,
   // and now and then a run with no gaps at all.
   function automatic int pick_gap();
      int roll;
      if ($urandom_range(0, 63) == 0) no_gap_run = !no_gap_run;
      if (no_gap_run) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Driver: presents backlog items at the falling edge. A presented item
   // stays on the port until it transfers (start high, busy low).
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else if (!req_start || req_taken) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_start <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_item  <= req_backlog.pop_front();
            req_start <= 1'b1;
            gap_left  <= pick_gap();
         end else begin
            req_start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: samples at the rising edge. Checks responses against the
   // oldest prediction, then folds this edge's register writes and request
   // transfer into the shadow state.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken    = 1'b0;
         stall_cycles = 0;
         rows_reg     = DIM_RESET;
         cols_reg     = DIM_RESET;
         for (int r = 0; r < GRID; r++)
            for (int c = 0; c < GRID; c++)
               wall_bits[r][c] = 1'b0;
      end else begin
         req_taken = req_start && !busy;
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               flag_mismatch($sformatf("response with none pending: found=%0b err=%0b",
                                       rsp_item.path_found, rsp_item.query_error));
            end else begin
               want = answers_due.pop_front();
               if (rsp_item.path_found !== want.path_found)
                  flag_mismatch($sformatf("path_found got %0b want %0b",
                                          rsp_item.path_found, want.path_found));
               if (rsp_item.query_error !== want.query_error)
                  flag_mismatch($sformatf("query_error got %0b want %0b",
                                          rsp_item.query_error, want.query_error));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NUM_ROWS: rows_reg = csr_data;
               CSR_NUM_COLS: cols_reg = csr_data;
               default: ;
            endcase
         end
         if (req_taken) begin
            items_taken++;
            if (req_item.op == OP_WRITE)
               wall_bits[req_item.cell_row][req_item.cell_col] = req_item.is_wall;
            else
               answers_due.push_back(reachable_answer(req_item));
         end
         stall_cycles = (req_taken || rsp_valid) ? 0 : stall_cycles + 1;
      end
   end

   // Watchdog: too long without any transfer means the block hung.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. Fields not used by an op still get random bits.
   // ------------------------------------------------------------------
   task automatic queue_write(int r, int c, bit wall);
      req_type item;
      item          = req_type'(REQ_W'($urandom));
      item.op       = OP_WRITE;
      item.cell_row = COORD_W'(r);
      item.cell_col = COORD_W'(c);
      item.is_wall  = wall;
      req_backlog.push_back(item);
      items_queued++;
   endtask

   task automatic queue_query(int sr, int sc, int er, int ec);
      req_type item;
      item           = req_type'(REQ_W'($urandom));
      item.op        = OP_QUERY;
      item.start_row = COORD_W'(sr);
      item.start_col = COORD_W'(sc);
      item.end_row   = COORD_W'(er);
      item.end_col   = COORD_W'(ec);
      req_backlog.push_back(item);
      items_queued++;
   endtask

   // Block is idle once every item has transferred and every answer came
   // back; a trailing write leaves nothing to wait on, so drain a while.
   task automatic wait_idle();
      while (!(items_taken == items_queued && answers_due.size() == 0 && !busy))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_dims(int rows, int cols);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_NUM_ROWS;
      csr_data  <= CSR_W'(rows);
      @(negedge clock);
      csr_index <= CSR_NUM_COLS;
      csr_data  <= CSR_W'(cols);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0:       return 0;                        // acts as one
         1:       return $urandom_range(GRID + 1, 31); // clamps to the store
         2:       return 1;
         3, 4:    return GRID;
         default: return $urandom_range(2, GRID);
      endcase
   endfunction

   // Full-store serpentine: odd rows are walls with one gap at alternating
   // ends, so the open corridor is as long as the grid allows.
   task automatic snake_round();
      set_dims(GRID, GRID);
      for (int r = 0; r < GRID; r++)
         for (int c = 0; c < GRID; c++)
            queue_write(r, c, (r % 2 == 1) && (c != ((r % 4 == 1) ? GRID - 1 : 0)));
      queue_query(0, 0, GRID - 2, 0);          // whole corridor
      queue_query(GRID - 2, 0, 0, 0);
      queue_query(0, 0, GRID - 1, GRID - 1);   // end is a wall
      queue_query(GRID - 1, 0, 0, 5);          // start sits in a gap
      queue_write(7, 0, 1'b1);                 // close a gap: snake splits
      queue_query(0, 0, GRID - 2, 0);
      queue_write(7, 0, 1'b0);
      queue_query(0, GRID - 1, GRID - 2, GRID - 1);
   endtask

   // One random round: new sizes, a batch of wall writes at some density,
   // then queries with a few writes mixed in.
   task automatic random_round();
      int rows, cols, rows_eff, cols_eff, density, sr, sc, kind;
      rows = pick_dim();
      cols = pick_dim();
      set_dims(rows, cols);
      rows_eff = eff_dim(CSR_W'(rows));
      cols_eff = eff_dim(CSR_W'(cols));
      density  = $urandom_range(0, 70);
      repeat ($urandom_range(4, 40)) begin
         if ($urandom_range(0, 9) == 0)
            // anywhere in the store, also outside the grid in use: must be kept
            queue_write($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                        $urandom_range(0, 99) < density);
         else
            queue_write($urandom_range(0, rows_eff - 1), $urandom_range(0, cols_eff - 1),
                        $urandom_range(0, 99) < density);
      end
      repeat ($urandom_range(4, 16)) begin
         if ($urandom_range(0, 3) == 0)
            queue_write($urandom_range(0, rows_eff - 1), $urandom_range(0, cols_eff - 1),
                        $urandom_range(0, 99) < density);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // anywhere in the coordinate range: mostly out of grid on small sizes
            queue_query($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                        $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1));
         end else if (kind == 1) begin
            sr = $urandom_range(0, rows_eff - 1);
            sc = $urandom_range(0, cols_eff - 1);
            queue_query(sr, sc, sr, sc);
         end else begin
            queue_query($urandom_range(0, rows_eff - 1), $urandom_range(0, cols_eff - 1),
                        $urandom_range(0, rows_eff - 1), $urandom_range(0, cols_eff - 1));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_start = 1'b0;
      req_item  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset sizes, all cells open.
      queue_query(0, 0, GRID - 1, GRID - 1);       // corner to corner
      queue_query(7, 7, 7, 7);                     // start equals end
      queue_write(GRID - 1, GRID - 1, 1'b1);
      queue_query(0, 0, GRID - 1, GRID - 1);       // end is a wall
      queue_query(GRID - 1, GRID - 1, GRID - 1, GRID - 1); // wall, but start equals end
      queue_write(0, 0, 1'b1);
      queue_query(0, 0, 0, 5);                     // start wall still passable
      queue_write(0, 1, 1'b1);
      queue_write(1, 0, 1'b1);
      queue_query(0, 0, 8, 8);                     // boxed in: search runs dry
      queue_write(0, 1, 1'b0);
      queue_query(0, 0, GRID - 2, GRID - 1);

      set_dims(0, 0);                              // zero acts as a 1x1 grid
      queue_query(0, 0, 0, 0);
      queue_query(0, 0, 0, 1);                     // out of grid
      queue_write(9, 9, 1'b1);                     // outside grid in use, kept

      set_dims(31, 31);                            // clamps to the full store
      queue_query(9, 8, 9, 9);                     // kept wall blocks the end
      queue_query(GRID - 1, 0, 0, GRID - 1);

      set_dims(3, GRID + 1);
      queue_query(2, GRID - 1, 3, 0);              // end row out of grid
      queue_query(0, GRID - 1, 2, GRID - 1);

      set_dims(GRID, 1);
      queue_query(GRID - 1, 0, 2, 0);
      queue_query(0, 0, 0, 1);                     // column out of grid

      snake_round();
      while (items_queued < ITEM_TARGET)
         random_round();

      wait_idle();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* grid_maze_path_search.f */
hdl/gmps_pkg.sv
hdl/gmps_cell.sv
hdl/grid_maze_path_search.sv
verif/tb.sv
